// ===== sv/cssl_pkg.sv =====
// shared types, constants and the rounding helper for the smoothing/sum block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cssl_pkg;

	localparam int DIMS      = 64;
	localparam int LAYERS    = 2;
	localparam int ENTRIES   = LAYERS * DIMS;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int LAYER_W   = 1;
	localparam int DIM_W     = 6;
	localparam int VAL_W     = 4;
	localparam int SUM_W     = 8;
	localparam int COEF_W    = 16;
	localparam int DECAY_W   = 14;
	localparam int FRAC_BITS = 13;
	localparam int PROD_W    = COEF_W + VAL_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int VAL_MAX   = 4;
	localparam int SUM_MAX   = 64;

	localparam logic [DECAY_W-1:0] ONE_Q13  = DECAY_W'(8192);
	localparam logic [DECAY_W-1:0] HALF_Q13 = DECAY_W'(4096);

	// request kinds carried on tuser
	localparam logic MODE_PROC = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [DECAY_W-1:0]       decay_t;
	typedef logic [IDX_W-1:0]         idx_t;

	typedef struct packed {
		val_t p2;
		val_t p1;
	} hist_t;

	typedef struct packed {
		coef_t  tap0;
		coef_t  tap1;
		coef_t  tap2;
		decay_t decay;
	} coef_set_t;

	typedef struct packed {
		val_t h;
		sum_t s;
	} smooth_t;

	typedef struct packed {
		logic vld;
		idx_t idx;
	} smooth_rd_t;

	typedef struct packed {
		logic   vld;
		logic   start;
		idx_t   idx;
		decay_t decay;
		val_t   y;
	} blend_req_t;

	typedef struct packed {
		val_t conv;
		val_t smooth;
		sum_t sum;
	} result_t;

	localparam coef_set_t COEF_RESET = '{tap0: '0, tap1: '0, tap2: '0, decay: HALF_Q13};

	// divide by 2^13 rounding half away from zero, then clamp to +-VAL_MAX
	function automatic val_t round_clamp(input logic signed [ACC_W-1:0] acc);
		logic                    neg;
		logic [ACC_W-1:0]        mag;
		logic [ACC_W-1:0]        rnd;
		logic [VAL_W-2:0]        vabs;
		val_t                    v;
		neg  = acc[ACC_W-1];
		mag  = neg ? ACC_W'(-acc) : ACC_W'(acc);
		rnd  = (mag + ACC_W'(HALF_Q13)) >> FRAC_BITS;
		vabs = (rnd > ACC_W'(VAL_MAX)) ? (VAL_W-1)'(VAL_MAX) : rnd[VAL_W-2:0];
		v    = $signed({1'b0, vabs});
		return neg ? -v : v;
	endfunction

endpackage

// ===== sv/conv_smooth_sum_layer_step.sv =====
// top level of the convolution, smoothing and running sum block
// depends on cssl_pkg, cssl_conv and cssl_blend
`timescale 1ns / 1ps

// One request per cycle on the s_ channel. s_tuser picks the kind: process an element
// of a (layer, dim) entry, or load that entry's three taps and blend factor.
// A process request yields one result on the m_ channel: the rounded clamped
// convolution, the new smoothed value and the new running sum. A load request, or one
// whose layer or dim lies outside the table, yields nothing.
// A process request passes through four register stages in all (state read and tap products,
// sum and round, blend and sum, output).
// Throughput: one request per cycle, also back to back on the same entry; the state of
// an entry is passed forward from the stage that last wrote it.
// Reset clears the valid bits of the per-entry state, so every entry reads as zero
// history, zero sums, zero taps and a blend factor of one half, without a clearing pass.
// A stall on m_tready freezes the whole pipeline and drops s_tready in the same cycle;
// nothing is lost or repeated, and the waiting result holds on m_tdata.
module conv_smooth_sum_layer_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// layer, dim[5:0], start_seq, elem_value[3:0], tap0_coef[15:0], tap1_coef[15:0],
	// tap2_coef[15:0], decay_coef[13:0], zero pad
	input  logic [79:0] s_tdata,
	// mode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// conv_out[3:0], smooth_out[3:0], sum_out[7:0]
	output logic [15:0] m_tdata
);
	import cssl_pkg::*;

	logic [LAYER_W-1:0] layer;
	logic [DIM_W-1:0]   dim;
	logic               start_seq;
	val_t               elem_value;
	coef_set_t          coef;
	logic               in_range;
	idx_t               idx;
	logic               en;
	logic               in_vld;
	smooth_rd_t         sm_rd;
	blend_req_t         blend_req;
	result_t            res;

	assign layer      = s_tdata[0];
	assign dim        = s_tdata[6:1];
	assign start_seq  = s_tdata[7];
	assign elem_value = s_tdata[11:8];
	assign coef.tap0  = s_tdata[27:12];
	assign coef.tap1  = s_tdata[43:28];
	assign coef.tap2  = s_tdata[59:44];
	assign coef.decay = s_tdata[73:60];

	assign in_range = (32'(layer) < LAYERS) && (32'(dim) < DIMS);
	assign idx      = IDX_W'(32'(layer) * DIMS + 32'(dim));

	// pipeline moves whenever the output register is empty or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign in_vld   = s_tvalid && in_range;

	cssl_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (in_vld),
		.in_mode   (s_tuser),
		.in_idx    (idx),
		.in_start  (start_seq),
		.in_elem   (elem_value),
		.in_coef   (coef),
		.sm_rd     (sm_rd),
		.blend_req (blend_req)
	);

	cssl_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.sm_rd   (sm_rd),
		.req     (blend_req),
		.out_vld (m_tvalid),
		.out_res (res)
	);

	assign m_tdata = {res.sum, res.smooth, res.conv};

endmodule

// ===== sv/cssl_conv.sv =====
// front of the pipeline: history and coefficient memories, tap products and convolution
// depends on cssl_pkg
`timescale 1ns / 1ps

module cssl_conv (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic                   in_mode,
	input  cssl_pkg::idx_t         in_idx,
	input  logic                   in_start,
	input  cssl_pkg::val_t         in_elem,
	input  cssl_pkg::coef_set_t    in_coef,
	output cssl_pkg::smooth_rd_t   sm_rd,
	output cssl_pkg::blend_req_t   blend_req
);
	import cssl_pkg::*;

	// memories
	hist_t     hist_mem [ENTRIES];
	coef_set_t coef_mem [ENTRIES];
	logic [ENTRIES-1:0] hist_vld_q;
	logic [ENTRIES-1:0] coef_vld_q;

	// stage 1
	logic      v_s1, mode_s1, start_s1;
	idx_t      idx_s1;
	val_t      elem_s1;
	coef_set_t ld_s1;
	hist_t     hist_rd_s1;
	coef_set_t coef_rd_s1;
	logic      hist_ok_s1, coef_ok_s1;

	// last write, for a request that read the memory in the same cycle
	logic      fw_hist_we_q, fw_coef_we_q;
	idx_t      fw_idx_q;
	hist_t     fw_hist_q;
	coef_set_t fw_coef_q;

	// stage 2
	logic                     v_s2, start_s2;
	idx_t                     idx_s2;
	decay_t                   decay_s2;
	logic signed [PROD_W-1:0] prod0_s2, prod1_s2, prod2_s2;

	// stage 3
	logic   v_s3, start_s3;
	idx_t   idx_s3;
	decay_t decay_s3;
	val_t   y_s3;

	coef_set_t                in_coef_sat;
	hist_t                    hist_old, hist_new;
	coef_set_t                coef_cur;
	val_t                     p2o, p1o;
	logic signed [PROD_W-1:0] prod0, prod1, prod2;
	logic signed [ACC_W-1:0]  acc;
	logic                     proc_s1, load_s1;

	always_comb begin
		in_coef_sat = in_coef;
		if (in_coef.decay > ONE_Q13) begin
			in_coef_sat.decay = ONE_Q13;
		end
	end

	// memory reads on accept
	always_ff @(posedge clk) begin
		if (en) begin
			hist_rd_s1 <= hist_mem[in_idx];
			coef_rd_s1 <= coef_mem[in_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (en && proc_s1) begin
			hist_mem[idx_s1] <= hist_new;
		end
		if (en && load_s1) begin
			coef_mem[idx_s1] <= ld_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q   <= '0;
			coef_vld_q   <= '0;
			hist_ok_s1   <= 1'b0;
			coef_ok_s1   <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			fw_hist_we_q <= 1'b0;
			fw_coef_we_q <= 1'b0;
		end else if (en) begin
			hist_ok_s1   <= hist_vld_q[in_idx];
			coef_ok_s1   <= coef_vld_q[in_idx];
			if (proc_s1) begin
				hist_vld_q[idx_s1] <= 1'b1;
			end
			if (load_s1) begin
				coef_vld_q[idx_s1] <= 1'b1;
			end
			v_s1         <= in_vld;
			v_s2         <= proc_s1;
			v_s3         <= v_s2;
			fw_hist_we_q <= proc_s1;
			fw_coef_we_q <= load_s1;
		end
	end

	// stage 1: resolve stored state, form the tap products
	always_comb begin
		proc_s1 = v_s1 && (mode_s1 == MODE_PROC);
		load_s1 = v_s1 && (mode_s1 == MODE_LOAD);

		if (fw_hist_we_q && (fw_idx_q == idx_s1)) begin
			hist_old = fw_hist_q;
		end else if (hist_ok_s1) begin
			hist_old = hist_rd_s1;
		end else begin
			hist_old = '0;
		end

		if (fw_coef_we_q && (fw_idx_q == idx_s1)) begin
			coef_cur = fw_coef_q;
		end else if (coef_ok_s1) begin
			coef_cur = coef_rd_s1;
		end else begin
			coef_cur = COEF_RESET;
		end

		p2o = start_s1 ? val_t'(0) : hist_old.p2;
		p1o = start_s1 ? val_t'(0) : hist_old.p1;

		hist_new.p2 = p1o;
		hist_new.p1 = elem_s1;

		prod0 = PROD_W'(coef_cur.tap0) * PROD_W'(p2o);
		prod1 = PROD_W'(coef_cur.tap1) * PROD_W'(p1o);
		prod2 = PROD_W'(coef_cur.tap2) * PROD_W'(elem_s1);
	end

	// stage 2: sum and round
	always_comb begin
		acc = ACC_W'(prod0_s2) + ACC_W'(prod1_s2) + ACC_W'(prod2_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= in_mode;
			idx_s1    <= in_idx;
			start_s1  <= in_start;
			elem_s1   <= in_elem;
			ld_s1     <= in_coef_sat;

			fw_idx_q  <= idx_s1;
			fw_hist_q <= hist_new;
			fw_coef_q <= ld_s1;

			idx_s2    <= idx_s1;
			start_s2  <= start_s1;
			decay_s2  <= coef_cur.decay;
			prod0_s2  <= prod0;
			prod1_s2  <= prod1;
			prod2_s2  <= prod2;

			idx_s3    <= idx_s2;
			start_s3  <= start_s2;
			decay_s3  <= decay_s2;
			y_s3      <= round_clamp(acc);
		end
	end

	assign sm_rd = '{vld: v_s2, idx: idx_s2};

	assign blend_req = '{vld: v_s3, start: start_s3, idx: idx_s3, decay: decay_s3, y: y_s3};

	a_hist_marked: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 && (mode_s1 == MODE_PROC) |=> hist_vld_q[$past(idx_s1)])
		else $error("history entry not marked after write");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (y_s3 >= -val_t'(VAL_MAX)) && (y_s3 <= val_t'(VAL_MAX)))
		else $error("convolution result out of range");

endmodule

// ===== sv/cssl_blend.sv =====
// back of the pipeline: smoothed value and running sum memory, alpha blend, result register
// depends on cssl_pkg
`timescale 1ns / 1ps

module cssl_blend (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cssl_pkg::smooth_rd_t   sm_rd,
	input  cssl_pkg::blend_req_t   req,
	output logic                   out_vld,
	output cssl_pkg::result_t      out_res
);
	import cssl_pkg::*;

	smooth_t            sm_mem [ENTRIES];
	logic [ENTRIES-1:0] sm_vld_q;

	smooth_t sm_rd_s3;
	logic    sm_ok_s3;

	logic    v_s4, start_s4;
	idx_t    idx_s4;
	result_t res_s4;

	smooth_t                  old_st;
	logic signed [DECAY_W:0]  a_w, b_w;
	logic signed [ACC_W-1:0]  mix;
	logic signed [SUM_W:0]    sum_w;
	sum_t                     sum_new;
	val_t                     h_new;

	always_ff @(posedge clk) begin
		if (en && sm_rd.vld) begin
			sm_rd_s3 <= sm_mem[sm_rd.idx];
		end
		if (en && req.vld) begin
			sm_mem[req.idx] <= '{h: h_new, s: sum_new};
		end
	end

	always_comb begin
		if (req.start) begin
			old_st = '0;
		end else if (v_s4 && (idx_s4 == req.idx)) begin
			old_st = '{h: res_s4.smooth, s: res_s4.sum};
		end else if (sm_ok_s3) begin
			old_st = sm_rd_s3;
		end else begin
			old_st = '0;
		end

		a_w = $signed({1'b0, req.decay});
		b_w = $signed({1'b0, ONE_Q13} - {1'b0, req.decay});
		mix = ACC_W'(a_w) * ACC_W'(old_st.h) + ACC_W'(b_w) * ACC_W'(req.y);
		h_new = round_clamp(mix);

		sum_w = (SUM_W+1)'(old_st.s) + (SUM_W+1)'(req.y);
		if (sum_w > (SUM_W+1)'(SUM_MAX)) begin
			sum_new = sum_t'(SUM_MAX);
		end else if (sum_w < -(SUM_W+1)'(SUM_MAX)) begin
			sum_new = -sum_t'(SUM_MAX);
		end else begin
			sum_new = sum_w[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sm_vld_q <= '0;
			sm_ok_s3 <= 1'b0;
			v_s4     <= 1'b0;
		end else if (en) begin
			if (sm_rd.vld) begin
				sm_ok_s3 <= sm_vld_q[sm_rd.idx];
			end
			if (req.vld) begin
				sm_vld_q[req.idx] <= 1'b1;
			end
			v_s4 <= req.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s4   <= req.idx;
			start_s4 <= req.start;
			res_s4   <= '{conv: req.y, smooth: h_new, sum: sum_new};
		end
	end

	assign out_vld = v_s4;
	assign out_res = res_s4;

	a_start_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && start_s4 |-> res_s4.sum == sum_t'(res_s4.conv))
		else $error("sum after sequence start differs from convolution");

	a_h_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (res_s4.smooth >= -val_t'(VAL_MAX)) && (res_s4.smooth <= val_t'(VAL_MAX)))
		else $error("smoothed value out of range");

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for conv_smooth_sum_layer_step: element and coefficient-load requests,
// results predicted per (layer, dim) entry and compared field by field
// depends on cssl_pkg and the rtl under sv/
`timescale 1ns / 1ps

module testbench;
	import cssl_pkg::*;

	typedef struct {
		logic   mode;
		logic   layer;
		logic   [DIM_W-1:0] dim;
		logic   start;
		val_t   elem;
		coef_t  tap0;
		coef_t  tap1;
		coef_t  tap2;
		decay_t decay;
		int     gap;
		bit     drain;
	} elem_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        s_tuser = MODE_PROC;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// per-entry copy of the block state
	val_t   hist2_mem  [ENTRIES];
	val_t   hist1_mem  [ENTRIES];
	val_t   smooth_mem [ENTRIES];
	sum_t   sum_mem    [ENTRIES];
	coef_t  tap0_mem   [ENTRIES];
	coef_t  tap1_mem   [ENTRIES];
	coef_t  tap2_mem   [ENTRIES];
	decay_t decay_mem  [ENTRIES];

	elem_req_t req_queue[$];
	result_t   pending_results[$];
	elem_req_t held;
	int        tx_wait = 0;
	bit        tx_calm = 0;
	int        rx_stall = 0;
	int        rx_calm = 0;
	int        fail_count = 0;

	conv_smooth_sum_layer_step DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// divide by 2^13, halves away from zero
	function automatic int div_q13(input int a);
		int mag;
		mag = (a < 0) ? -a : a;
		mag = (mag + int'(HALF_Q13)) >> FRAC_BITS;
		return (a < 0) ? -mag : mag;
	endfunction

	function automatic int clip(input int v, input int lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic void apply_request(input elem_req_t r);
		int      idx, p2, p1, h_old, s_old, acc, y, h, s, a;
		result_t res;
		idx = int'(r.layer) * DIMS + int'(r.dim);
		if (r.mode == MODE_LOAD) begin
			tap0_mem[idx]  = r.tap0;
			tap1_mem[idx]  = r.tap1;
			tap2_mem[idx]  = r.tap2;
			decay_mem[idx] = (r.decay > ONE_Q13) ? ONE_Q13 : r.decay;
			return;
		end
		if (r.start) begin
			p2 = 0;
			p1 = 0;
			h_old = 0;
			s_old = 0;
		end else begin
			p2 = int'(hist2_mem[idx]);
			p1 = int'(hist1_mem[idx]);
			h_old = int'(smooth_mem[idx]);
			s_old = int'(sum_mem[idx]);
		end
		acc = int'(tap0_mem[idx]) * p2 + int'(tap1_mem[idx]) * p1 + int'(tap2_mem[idx]) * int'(r.elem);
		y = clip(div_q13(acc), VAL_MAX);
		a = int'(decay_mem[idx]);
		h = clip(div_q13(a * h_old + (int'(ONE_Q13) - a) * y), VAL_MAX);
		s = clip(s_old + y, SUM_MAX);
		hist2_mem[idx]  = val_t'(p1);
		hist1_mem[idx]  = r.elem;
		smooth_mem[idx] = val_t'(h);
		sum_mem[idx]    = sum_t'(s);
		res.conv   = val_t'(y);
		res.smooth = val_t'(h);
		res.sum    = sum_t'(s);
		pending_results = {pending_results, res};
	endfunction

	task automatic add_req(input logic mode, input int entry, input logic start, input int elem,
			input int t0, input int t1, input int t2, input int decay, input bit drain);
		elem_req_t r;
		r.mode  = mode;
		r.layer = LAYER_W'(entry / DIMS);
		r.dim   = DIM_W'(entry % DIMS);
		r.start = start;
		r.elem  = val_t'(elem);
		r.tap0  = coef_t'(t0);
		r.tap1  = coef_t'(t1);
		r.tap2  = coef_t'(t2);
		r.decay = decay_t'(decay);
		r.gap   = tx_calm ? 0 : $urandom_range(0, 19);
		r.drain = drain;
		req_queue = {req_queue, r};
	endtask

	function automatic int rand_tap(input int style);
		case (style)
			0: return $urandom_range(0, 65535);
			1: return int'($urandom_range(0, 16383)) - 8192;
			default: return $urandom_range(4096, 32767);
		endcase
	endfunction

	task automatic load_random(input int entry);
		int style, decay;
		style = $urandom_range(0, 2);
		case ($urandom_range(0, 3))
			0: decay = $urandom_range(0, 16383);
			1: decay = $urandom_range(0, 8192);
			2: decay = $urandom_range(0, 1) ? 0 : 8192;
			default: decay = $urandom_range(8190, 16383);
		endcase
		add_req(MODE_LOAD, entry, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
			rand_tap(style), rand_tap(style), rand_tap(style), decay, $urandom_range(0, 199) == 0);
	endtask

	function automatic int rand_elem(input int bias);
		case (bias)
			0: return $urandom_range(0, 15);
			1: return $urandom_range(1, 7);
			2: return $urandom_range(8, 15);
			default: return int'($urandom_range(0, 8)) - 4;
		endcase
	endfunction

	// request driver: holds each request until accepted, then waits out the next one's gap
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				apply_request(held);
			if (!(s_tvalid && !s_tready)) begin
				if (tx_wait > 0) begin
					s_tvalid <= 1'b0;
					tx_wait--;
				end else if (req_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (req_queue[0].drain && pending_results.size() != 0) begin
					s_tvalid <= 1'b0;
				end else begin
					held = req_queue.pop_front();
					s_tuser  <= held.mode;
					s_tdata  <= {6'b0, held.decay, held.tap2, held.tap1, held.tap0, held.elem,
						held.start, held.dim, held.layer};
					s_tvalid <= 1'b1;
					tx_wait = (req_queue.size() != 0) ? req_queue[0].gap : 0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: m_tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[3:0] !== want.conv) begin
						$error("conv_out: expected %0d, got %0d", want.conv, $signed(m_tdata[3:0]));
						fail_count++;
					end
					if (m_tdata[7:4] !== want.smooth) begin
						$error("smooth_out: expected %0d, got %0d", want.smooth,
							$signed(m_tdata[7:4]));
						fail_count++;
					end
					if (m_tdata[15:8] !== want.sum) begin
						$error("sum_out: expected %0d, got %0d", want.sum, $signed(m_tdata[15:8]));
						fail_count++;
					end
				end
				if (rx_calm > 0)
					rx_calm--;
				else if ($urandom_range(0, 19) == 0)
					rx_calm = $urandom_range(10, 40);
				rx_stall = (rx_calm > 0) ? 0 : $urandom_range(0, 19);
			end
			if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int  e0, e1, e, len, bias, k, i;
		bit  first0, first1, st;
		for (i = 0; i < ENTRIES; i++) begin
			hist2_mem[i]  = '0;
			hist1_mem[i]  = '0;
			smooth_mem[i] = '0;
			sum_mem[i]    = '0;
			tap0_mem[i]   = '0;
			tap1_mem[i]   = '0;
			tap2_mem[i]   = '0;
			decay_mem[i]  = HALF_Q13;
		end

		// directed: reset contents, unit taps, full-scale taps, exact halves, decay limits
		add_req(MODE_PROC, 0, 1, 0, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, ENTRIES - 1, 0, 7, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, ENTRIES - 1, 0, -8, 0, 0, 0, 0, 0);
		add_req(MODE_LOAD, 0, 0, 0, 8192, 8192, 8192, 16383, 0);
		add_req(MODE_PROC, 0, 1, 4, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, 0, 0, 3, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, 0, 0, -8, 0, 0, 0, 0, 0);
		add_req(MODE_LOAD, ENTRIES - 1, 0, 0, 32767, -32768, 32767, 0, 0);
		add_req(MODE_PROC, ENTRIES - 1, 1, 7, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, ENTRIES - 1, 0, -8, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, ENTRIES - 1, 0, -8, 0, 0, 0, 0, 0);
		add_req(MODE_LOAD, 5, 0, 0, 0, 0, 4096, 8192, 0);
		add_req(MODE_PROC, 5, 1, 1, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, 5, 0, -1, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, 5, 0, 3, 0, 0, 0, 0, 0);
		add_req(MODE_LOAD, 5, 0, 0, 0, 0, 12288, 8193, 0);
		add_req(MODE_PROC, 5, 0, -1, 0, 0, 0, 0, 0);
		add_req(MODE_LOAD, DIMS + 42, 0, 0, -32768, -32768, -32768, 4096, 0);
		add_req(MODE_PROC, DIMS + 42, 1, 7, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, DIMS + 42, 0, 7, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, DIMS + 42, 0, 7, 0, 0, 0, 0, 0);
		add_req(MODE_PROC, DIMS + 42, 1, -8, 0, 0, 0, 0, 0);
		// load with start and element set, both ignored; sent only once the pipe is empty
		add_req(MODE_LOAD, 21, 1, 5, 1, -1, 8191, 1, 1);
		add_req(MODE_PROC, 21, 0, 0, 0, 0, 0, 0, 0);

		// random: sequences on one or two entries, optional reload, some noise
		while (req_queue.size() < 1575) begin
			e0 = $urandom_range(0, ENTRIES - 1);
			e1 = $urandom_range(0, 1) ? e0 : $urandom_range(0, ENTRIES - 1);
			tx_calm = ($urandom_range(0, 3) == 0);
			bias = $urandom_range(0, 3);
			if ($urandom_range(0, 1))
				load_random(e0);
			if (e1 != e0 && $urandom_range(0, 1))
				load_random(e1);
			len = $urandom_range(1, 40);
			first0 = 1;
			first1 = 1;
			for (k = 0; k < len; k++) begin
				e = $urandom_range(0, 1) ? e0 : e1;
				st = (e == e0) ? first0 : first1;
				if ($urandom_range(0, 29) == 0)
					st = !st;
				if (e == e0)
					first0 = 0;
				if (e == e1)
					first1 = 0;
				if ($urandom_range(0, 49) == 0)
					load_random(e);
				else
					add_req(MODE_PROC, e, st, rand_elem(bias), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 16383), $urandom_range(0, 199) == 0);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// sampled away from the rising edge so the driver's updates have settled
		while (req_queue.size() != 0 || s_tvalid)
			@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
